/* rtl/core/sha_pkg.sv */
// Shared types and constants for the SHA-256 stream hasher.
// Holds the round constants, initial hash values and controller command types.
// No dependencies.
`default_nettype none
package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic       take_byte;   // write s_tdata byte at fill position
        logic       pad_write;   // write padding byte at pad position
        logic [1:0] pad_kind;    // padding byte type
        logic       comp_start;  // load schedule and working variables
        logic       comp_round;  // perform one round
        logic       comp_fold;   // add working variables into hash
        logic       msg_init;    // restore initial hash, clear counters
        logic       out_load;    // load output word
        logic       count_block; // add 512 to bit count, clear fill
    } sha_cmd_t;

    typedef struct packed {
        logic [6:0] fill;
        logic [5:0] round;
    } sha_stat_t;

    localparam logic [1:0] PAD_MARK = 2'd0;
    localparam logic [1:0] PAD_ZERO = 2'd1;
    localparam logic [1:0] PAD_LEN  = 2'd2;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage
`default_nettype wire

/* rtl/core/sha_datapath.sv */
// Datapath of the SHA-256 hasher: block buffer, schedule, rounds and hash.
// Driven by sha_ctrl through sha_cmd_t; depends on sha_pkg.
`default_nettype none
module sha_datapath
    import sha_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire sha_cmd_t   cmd,
    input  wire logic [7:0] in_byte,
    input  wire logic [5:0] pad_pos,
    input  wire logic [2:0] out_sel,
    output sha_stat_t       stat,
    output word_t           out_word
);

    word_t      blk_reg [16];
    word_t      w_reg [16];
    word_t      v_reg [8];
    word_t      h_reg [8];
    logic [6:0] fill_reg;
    logic [5:0] round_reg;
    logic [63:0] bits_reg;
    logic [63:0] total;
    word_t      wt, w2, w15, g0, g1, s0, s1, ch, mj, t1, t2;
    logic [7:0] pad_byte;

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    assign total = bits_reg + {54'd0, fill_reg[5:0], 3'd0};
    assign stat  = '{fill: fill_reg, round: round_reg};

    always_comb begin
        unique case (cmd.pad_kind)
            PAD_MARK: pad_byte = PAD_BYTE;
            PAD_LEN:  pad_byte = total[8*(63-pad_pos) +: 8];
            default:  pad_byte = 8'd0;
        endcase
    end

    assign w2  = w_reg[14];
    assign w15 = w_reg[1];
    assign g1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    assign g0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    assign wt  = (round_reg < 6'd16) ? w_reg[0] : g1 + w_reg[9] + g0 + w_reg[0];
    assign s1  = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + s1 + ch + ROUND_K[round_reg] + wt;
    assign s0  = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
    assign mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = s0 + mj;

    always_ff @(posedge aclk) begin
        if (cmd.take_byte) begin
            blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= in_byte;
        end else if (cmd.pad_write) begin
            blk_reg[pad_pos[5:2]][8*(3-pad_pos[1:0]) +: 8] <= pad_byte;
        end
        if (cmd.comp_start) begin
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= blk_reg[i];
            end
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.comp_round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.out_load) begin
            out_word <= h_reg[out_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.msg_init) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_HASH[i];
            end
            fill_reg  <= 7'd0;
            bits_reg  <= 64'd0;
            round_reg <= 6'd0;
        end else begin
            if (cmd.comp_fold) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.count_block) begin
                fill_reg <= 7'd0;
                bits_reg <= bits_reg + 64'd512;
            end else if (cmd.take_byte) begin
                fill_reg <= fill_reg + 7'd1;
            end
            if (cmd.comp_start) begin
                round_reg <= 6'd0;
            end else if (cmd.comp_round) begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sha_ctrl.sv */
// Controller of the SHA-256 hasher: sequences byte intake, padding,
// compression and digest output. Depends on sha_pkg.
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire logic  in_present,
    input  wire logic  in_end,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [2:0] out_idx,
    output logic [2:0] out_sel,
    output logic [5:0] pad_pos,
    output sha_cmd_t   cmd,
    input  wire sha_stat_t stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       end_reg, end_next;
    logic       final_reg, final_next;
    logic [5:0] pos_reg, pos_next;
    logic       mark_reg, mark_next;
    logic [2:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic       acc;
    logic       full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_valid && in_ready;
    assign full      = stat.fill == 7'd64;
    assign out_valid = ov_reg;
    assign out_idx   = idx_reg;
    assign pad_pos   = pos_reg;

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        final_next = final_reg;
        pos_next   = pos_reg;
        mark_next  = mark_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        out_sel    = idx_reg;
        cmd        = '0;
        cmd.pad_kind = PAD_ZERO;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.take_byte = in_present;
                    end_next = in_end;
                    if (in_present && stat.fill == 7'd63) begin
                        state_next = ST_START;
                        final_next = 1'b0;
                    end else if (in_end) begin
                        state_next = ST_PAD;
                        pos_next   = in_present ? stat.fill[5:0] + 6'd1 : stat.fill[5:0];
                        mark_next  = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                cmd.pad_write = 1'b1;
                if (mark_reg) begin
                    cmd.pad_kind = PAD_MARK;
                end else if (pos_reg >= LEN_POS && final_reg) begin
                    cmd.pad_kind = PAD_LEN;
                end
                mark_next = 1'b0;
                pos_next  = pos_reg + 6'd1;
                if (mark_reg) begin
                    final_next = pos_reg < LEN_POS;
                end
                if (pos_reg == 6'd63) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.comp_start = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.comp_round = 1'b1;
                if (stat.round == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.comp_fold = 1'b1;
                if (full) begin
                    cmd.count_block = 1'b1;
                end
                if (full && !end_reg) begin
                    state_next = ST_IDLE;
                end else if (full || !final_reg) begin
                    state_next = ST_PAD;
                    pos_next   = 6'd0;
                    mark_next  = full;
                    final_next = 1'b1;
                end else begin
                    state_next = ST_OUT;
                    idx_next   = 3'd0;
                    ov_next    = 1'b0;
                end
            end
            ST_OUT: begin
                if (!ov_reg || out_ready) begin
                    if (ov_reg && idx_reg == 3'd7) begin
                        ov_next    = 1'b0;
                        cmd.msg_init = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        out_sel  = ov_reg ? idx_reg + 3'd1 : idx_reg;
                        idx_next = out_sel;
                        cmd.out_load = 1'b1;
                        ov_next  = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            end_reg   <= 1'b0;
            final_reg <= 1'b0;
            mark_reg  <= 1'b0;
            idx_reg   <= 3'd0;
            pos_reg   <= 6'd0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            end_reg   <= end_next;
            final_reg <= final_next;
            mark_reg  <= mark_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: joins controller and datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Input channel s_*: one message byte per transaction in s_tdata, with
// s_tuser marking whether the byte is present and s_tlast ending the message.
// Output channel m_*: eight transactions per message, digest word 0 first,
// m_tlast on the eighth word, m_tuser giving the word index.
// A byte that does not complete a block leaves s_tready high. A byte that fills a
// block holds s_tready low while the block is compressed: one schedule load, 64 rounds
// through the single shared round unit and one hash fold. An end transaction
// pads the block one byte a cycle, compresses once or twice, then offers the words.
// While the receiver stalls, each word holds on m_tdata and no new input
// transaction is taken until the last word has gone. Reset (aresetn low,
// synchronous) restores the initial hash and empties the block.
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
    input  wire logic        s_tuser,  // [0] byte_present
    input  wire logic        s_tlast,  // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // [31:0] digest_word
    output logic [2:0]       m_tuser,  // [2:0] word_index
    output logic             m_tlast   // last_word
);

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] out_sel;
    logic [5:0] pad_pos;

    sha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_present(s_tuser), .in_end(s_tlast),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_idx(m_tuser), .out_sel(out_sel), .pad_pos(pad_pos),
        .cmd(cmd), .stat(stat)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_byte(s_tdata),
        .pad_pos(pad_pos), .out_sel(out_sel), .stat(stat), .out_word(m_tdata)
    );

    assign m_tlast = m_tuser == 3'd7;

`ifndef SYNTHESIS
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during digest output");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> stat.fill < 7'd64) else $error("fill beyond block");
    a_word_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest words out of order");
`endif

endmodule
`default_nettype wire
